// ===== hdl/dqkr_pkg.sv =====
// ----------------------------------------------------------------------------
// dqkr_pkg
// shared types and constants of the deque with key removal
// ----------------------------------------------------------------------------
package dqkr_pkg;

  localparam int Depth    = 16;
  localparam int WordBits = 32;
  localparam int CntBits  = $clog2(Depth + 1);
  localparam int IdxBits  = $clog2(Depth);
  localparam int SumBits  = WordBits + IdxBits + 1;

  typedef logic signed [WordBits-1:0] word_t;
  typedef logic [CntBits-1:0] cnt_t;

  typedef enum logic [2:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_REMOVE     = 3'd4,
    MODE_AVERAGE    = 3'd5,
    MODE_REPLACE    = 3'd6,
    MODE_CLEAR      = 3'd7
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_SHIFT_IN,    // shift toward back, take the word of the previous cell
    CMD_SHIFT_OUT,   // shift toward front
    CMD_ROTATE,      // take the word of the front cell
    CMD_LOAD_BACK    // load the data word
  } cmd_e;

  typedef struct packed {
    cmd_e  cmd;
    word_t data;
  } cell_ctl_t;

  typedef enum logic [2:0] {
    FSM_IDLE,
    FSM_WALK,
    FSM_DIV,
    FSM_FIX,
    FSM_OUT
  } fsm_e;

endpackage

// ===== hdl/dqkr_cell.sv =====
// ----------------------------------------------------------------------------
// dqkr_cell
// one storage slot of the chain; takes data from a neighbor, the front cell or the bus
// ----------------------------------------------------------------------------
module dqkr_cell import dqkr_pkg::*; (
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  word_t     prev_i,
  input  word_t     next_i,
  input  word_t     head_i,
  output word_t     word_o
);

  word_t word_q, word_d;

  always_comb begin
    word_d = word_q;
    unique case (ctl_i.cmd)
      CMD_HOLD:      word_d = word_q;
      CMD_SHIFT_IN:  word_d = prev_i;
      CMD_SHIFT_OUT: word_d = next_i;
      CMD_ROTATE:    word_d = head_i;
      CMD_LOAD_BACK: word_d = ctl_i.data;
      default:       word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;

endmodule

// ===== hdl/dqkr_divider.sv =====
// ----------------------------------------------------------------------------
// dqkr_divider
// restoring divider, signed sum by unsigned count, one quotient bit a cycle
// ----------------------------------------------------------------------------
module dqkr_divider import dqkr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [SumBits-1:0] sum_i,
  input  cnt_t               cnt_i,
  output logic               done_o,
  output word_t              quot_o
);

  localparam int StepBits = $clog2(SumBits + 1);

  logic [SumBits-1:0]  rem_q, rem_d, quo_q, quo_d;
  logic [CntBits-1:0]  div_q, div_d;
  logic [StepBits-1:0] step_q, step_d;
  logic                busy_q, busy_d, neg_q, neg_d;
  logic [SumBits:0]    trial;
  logic [SumBits-1:0]  mag;
  logic [SumBits-1:0]  res;

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    div_d  = div_q;
    step_d = step_q;
    busy_d = busy_q;
    neg_d  = neg_q;
    mag    = sum_i[SumBits-1] ? (~sum_i + 1'b1) : sum_i;
    trial  = {rem_q, quo_q[SumBits-1]} - {{(SumBits + 1 - CntBits){1'b0}}, div_q};
    if (start_i) begin
      rem_d  = '0;
      quo_d  = mag;
      div_d  = cnt_i;
      neg_d  = sum_i[SumBits-1];
      step_d = StepBits'(SumBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[SumBits]) begin
        rem_d = trial[SumBits-1:0];
        quo_d = {quo_q[SumBits-2:0], 1'b1};
      end else begin
        rem_d = {rem_q[SumBits-2:0], quo_q[SumBits-1]};
        quo_d = {quo_q[SumBits-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      if (step_q == StepBits'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    div_q <= div_d;
    neg_q <= neg_d;
  end

  assign res    = neg_q ? (~quo_q + 1'b1) : quo_q;
  assign quot_o = res[WordBits-1:0];
  assign done_o = !busy_q;

endmodule

// ===== hdl/deque_with_key_removal_top.sv =====
// ----------------------------------------------------------------------------
// deque_with_key_removal_top
// bounded deque of signed words held in a chain of shifting cells
// ----------------------------------------------------------------------------
// One request at a time; the next request is taken the cycle after a result
// leaves. Push, pop and clear give their result the cycle after the accept.
// Remove-key, average and replace-even walk the live entries once, one per
// cycle: the front word leaves cell 0 and, unless removed, re-enters behind
// the words already walked. Average then runs the serial divider, and
// replace-even walks once more to write the average over each even word.
// On an empty queue these three answer the cycle after the accept. The
// front of the queue is cell 0.
module deque_with_key_removal_top import dqkr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  mode_i,
  input  word_t       operand_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output word_t       word_out_o,
  output logic [4:0]  removed_count_o,
  output logic [4:0]  length_o,
  output logic [1:0]  status_o
);

  fsm_e  state_q, state_d;
  mode_e mode_q;
  word_t key_q, avg_q;
  cnt_t  fill_q, fill_d, rem_q, rem_d;
  logic [IdxBits:0] walk_q, walk_d;
  logic [SumBits-1:0] sum_q, sum_d;
  logic  fix_q, fix_d;
  word_t word_q, word_d;
  logic [1:0] stat_q, stat_d;

  word_t     cell_w [Depth];
  cell_ctl_t ctl    [Depth];

  logic  div_start, div_done;
  word_t div_quot;
  logic  accept;
  mode_e in_mode;
  word_t head;
  logic [IdxBits-1:0] tail;
  logic  last_step;

  assign in_mode = mode_e'(mode_i);
  assign accept  = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == FSM_IDLE) && !out_valid_o;
  assign head    = cell_w[0];
  // slot behind the live words once the chain has shifted
  assign tail      = IdxBits'(fill_q - rem_q - 1'b1);
  assign last_step = walk_q == (IdxBits + 1)'(fill_q - 1'b1);

  // chain: cell i sees neighbors i-1 and i+1; the back wraps to the front
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    word_t prev_w, next_w;
    if (g == 0) begin : g_first
      assign prev_w = '0;
    end else begin : g_mid
      assign prev_w = cell_w[g-1];
    end
    if (g == Depth - 1) begin : g_last
      assign next_w = cell_w[0];
    end else begin : g_rest
      assign next_w = cell_w[g+1];
    end
    dqkr_cell u_cell (
      .clk_i  (clk_i),
      .ctl_i  (ctl[g]),
      .prev_i (prev_w),
      .next_i (next_w),
      .head_i (cell_w[0]),
      .word_o (cell_w[g])
    );
  end

  dqkr_divider u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .sum_i   (sum_d),
    .cnt_i   (fill_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          if ((in_mode == MODE_REMOVE || in_mode == MODE_AVERAGE ||
               in_mode == MODE_REPLACE) && fill_q != '0) begin
            state_d = FSM_WALK;
          end else begin
            state_d = FSM_OUT;
          end
        end
      end
      FSM_WALK: begin
        if (last_step) begin
          if (mode_q == MODE_REMOVE || fix_q) state_d = FSM_OUT;
          else state_d = FSM_DIV;
        end
      end
      FSM_DIV:  if (div_done && !div_start) state_d = FSM_FIX;
      FSM_FIX:  state_d = (mode_q == MODE_REPLACE) ? FSM_WALK : FSM_OUT;
      FSM_OUT:  if (out_ready_i) state_d = FSM_IDLE;
      default:  state_d = FSM_IDLE;
    endcase
  end

  // datapath and cell commands
  always_comb begin
    fill_d    = fill_q;
    rem_d     = rem_q;
    walk_d    = walk_q;
    sum_d     = sum_q;
    fix_d     = fix_q;
    word_d    = word_q;
    stat_d    = stat_q;
    div_start = 1'b0;
    for (int i = 0; i < Depth; i++) begin
      ctl[i].cmd  = CMD_HOLD;
      ctl[i].data = operand_i;
    end
    unique case (state_q)
      FSM_IDLE: begin
        if (accept) begin
          word_d = '0;
          rem_d  = '0;
          stat_d = ST_OK;
          walk_d = '0;
          sum_d  = '0;
          fix_d  = 1'b0;
          case (in_mode)
            MODE_PUSH_FRONT: begin
              if (fill_q == cnt_t'(Depth)) stat_d = ST_FULL;
              else begin
                for (int i = 1; i < Depth; i++) ctl[i].cmd = CMD_SHIFT_IN;
                ctl[0].cmd = CMD_LOAD_BACK;
                fill_d = fill_q + 1'b1;
              end
            end
            MODE_PUSH_BACK: begin
              if (fill_q == cnt_t'(Depth)) stat_d = ST_FULL;
              else begin
                ctl[fill_q[IdxBits-1:0]].cmd = CMD_LOAD_BACK;
                fill_d = fill_q + 1'b1;
              end
            end
            MODE_POP_FRONT: begin
              if (fill_q == '0) stat_d = ST_EMPTY;
              else begin
                word_d = cell_w[0];
                for (int i = 0; i < Depth; i++) ctl[i].cmd = CMD_SHIFT_OUT;
                fill_d = fill_q - 1'b1;
              end
            end
            MODE_POP_BACK: begin
              if (fill_q == '0) stat_d = ST_EMPTY;
              else begin
                word_d = cell_w[IdxBits'(fill_q - 1'b1)];
                fill_d = fill_q - 1'b1;
              end
            end
            MODE_CLEAR: fill_d = '0;
            default: begin
              if (fill_q == '0 && in_mode != MODE_REMOVE) stat_d = ST_EMPTY;
            end
          endcase
        end
      end
      FSM_WALK: begin
        // front leaves; a kept word re-enters behind the walked words
        for (int i = 0; i < Depth; i++) ctl[i].cmd = CMD_SHIFT_OUT;
        if (mode_q == MODE_REMOVE) begin
          if (head == key_q) rem_d = rem_q + 1'b1;
          else ctl[tail].cmd = CMD_ROTATE;
        end else if (fix_q && !head[0]) begin
          ctl[tail].cmd  = CMD_LOAD_BACK;
          ctl[tail].data = avg_q;
        end else begin
          ctl[tail].cmd = CMD_ROTATE;
          if (!fix_q) sum_d = sum_q + SumBits'(head);
        end
        walk_d = walk_q + 1'b1;
        if (last_step) begin
          walk_d = '0;
          if (mode_q == MODE_REMOVE) fill_d = fill_q - rem_d;
          else if (!fix_q) div_start = 1'b1;
        end
      end
      FSM_DIV: ;
      FSM_FIX: begin
        word_d = div_quot;
        fix_d  = 1'b1;
      end
      FSM_OUT: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FSM_IDLE;
      fill_q  <= '0;
      walk_q  <= '0;
      fix_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      walk_q  <= walk_d;
      fix_q   <= fix_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= in_mode;
      key_q  <= operand_i;
    end
    if (state_q == FSM_FIX) avg_q <= div_quot;
    rem_q  <= rem_d;
    sum_q  <= sum_d;
    word_q <= word_d;
    stat_q <= stat_d;
  end

  assign out_valid_o     = (state_q == FSM_OUT);
  assign word_out_o      = word_q;
  assign removed_count_o = 5'(rem_q);
  assign length_o        = 5'(fill_q);
  assign status_o        = stat_q;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= cnt_t'(Depth)) else $error("fill count above depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != FSM_IDLE) |-> !in_ready_o) else $error("ready while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o && $stable(word_out_o))
    else $error("result dropped");
`endif

endmodule

// ===== tb/deque_with_key_removal_checker.sv =====
// ----------------------------------------------------------------------------
// deque_with_key_removal_checker
// watches both channels, keeps a copy of the deque and compares every result
// ----------------------------------------------------------------------------
module deque_with_key_removal_checker import dqkr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [2:0] mode_i,
  input  word_t      operand_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  word_t      word_out_i,
  input  logic [4:0] removed_count_i,
  input  logic [4:0] length_i,
  input  logic [1:0] status_i,
  output int         fail_count_o,
  output int         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    word_t      word;
    logic [4:0] removed;
    logic [4:0] len;
    logic [1:0] status;
  } deque_result_t;

  word_t         shadow_q[$];
  deque_result_t result_fifo[$];

  assign pending_o = result_fifo.size();

  function automatic deque_result_t apply_request(input logic [2:0] mode,
                                                  input word_t opnd);
    deque_result_t r;
    word_t kept[$];
    longint sum;
    r = '0;
    case (mode_e'(mode))
      MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
        if (shadow_q.size() >= Depth) r.status = ST_FULL;
        else if (mode == MODE_PUSH_FRONT) shadow_q.push_front(opnd);
        else shadow_q.push_back(opnd);
      end
      MODE_POP_FRONT, MODE_POP_BACK: begin
        if (shadow_q.size() == 0) r.status = ST_EMPTY;
        else if (mode == MODE_POP_FRONT) r.word = shadow_q.pop_front();
        else r.word = shadow_q.pop_back();
      end
      MODE_REMOVE: begin
        foreach (shadow_q[i]) begin
          if (shadow_q[i] == opnd) r.removed++;
          else kept.push_back(shadow_q[i]);
        end
        shadow_q = kept;
      end
      MODE_AVERAGE, MODE_REPLACE: begin
        if (shadow_q.size() == 0) r.status = ST_EMPTY;
        else begin
          sum = 0;
          foreach (shadow_q[i]) sum += longint'(shadow_q[i]);
          // longint division truncates toward zero
          r.word = word_t'(sum / longint'(shadow_q.size()));
          if (mode == MODE_REPLACE)
            foreach (shadow_q[i]) if (!shadow_q[i][0]) shadow_q[i] = r.word;
        end
      end
      default: shadow_q.delete();
    endcase
    r.len = 5'(shadow_q.size());
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t exp_r;
    if (!rst_ni) begin
      shadow_q.delete();
      result_fifo.delete();
      fail_count_o <= 0;
    end else begin
      if (in_valid_i && in_ready_i)
        result_fifo.push_back(apply_request(mode_i, operand_i));
      if (out_valid_i && out_ready_i) begin
        if (result_fifo.size() == 0) begin
          $error("result with no request pending");
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_r = result_fifo.pop_front();
          if (word_out_i !== exp_r.word || removed_count_i !== exp_r.removed ||
              length_i !== exp_r.len || status_i !== exp_r.status)
            fail_count_o <= fail_count_o + 1;
          if (word_out_i !== exp_r.word)
            $error("word_out expected %0d actual %0d", exp_r.word, word_out_i);
          if (removed_count_i !== exp_r.removed)
            $error("removed_count expected %0d actual %0d", exp_r.removed,
                   removed_count_i);
          if (length_i !== exp_r.len)
            $error("length expected %0d actual %0d", exp_r.len, length_i);
          if (status_i !== exp_r.status)
            $error("status expected %0d actual %0d", exp_r.status, status_i);
        end
      end
    end
  end
endmodule

// ===== tb/deque_with_key_removal_top_tb.sv =====
// ----------------------------------------------------------------------------
// deque_with_key_removal_top_tb
// directed and random deque requests with random stalls on both channels
// ----------------------------------------------------------------------------
module deque_with_key_removal_top_tb;
  import dqkr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 2000;

  logic       clk, rst_n;
  logic       in_valid, in_ready, out_valid, out_ready;
  logic [2:0] mode;
  word_t      operand, word_out;
  logic [4:0] removed_count, length;
  logic [1:0] status;
  int         fail_count, pending, idle_cycles;
  bit         quiet;

  deque_with_key_removal_top uut (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_o(in_ready),
    .mode_i(mode), .operand_i(operand), .out_valid_o(out_valid),
    .out_ready_i(out_ready), .word_out_o(word_out), .removed_count_o(removed_count),
    .length_o(length), .status_o(status)
  );

  deque_with_key_removal_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n), .in_valid_i(in_valid), .in_ready_i(in_ready),
    .mode_i(mode), .operand_i(operand), .out_valid_i(out_valid),
    .out_ready_i(out_ready), .word_out_i(word_out), .removed_count_i(removed_count),
    .length_i(length), .status_i(status), .fail_count_o(fail_count),
    .pending_o(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk) out_ready <= quiet || $urandom_range(99) >= 30;

  // valid stays high into the next request unless an idle cycle comes first
  task automatic send_request(input mode_e m, input word_t d);
    while (!quiet && $urandom_range(99) < 30) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    mode     <= m;
    operand  <= d;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic word_t pick_word();
    case ($urandom_range(5))
      0: return word_t'($urandom_range(7)) - 3;
      1: return 32'sh7fffffff;
      2: return 32'sh80000000;
      default: return word_t'($urandom);
    endcase
  endfunction

  initial begin
    word_t key;
    quiet = 0;
    in_valid = 0;
    mode = MODE_CLEAR;
    operand = '0;
    rst_n = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // empty cases, then fill past full with extremes
    send_request(MODE_POP_FRONT, 0);
    send_request(MODE_POP_BACK, 0);
    send_request(MODE_AVERAGE, 0);
    send_request(MODE_REPLACE, 0);
    send_request(MODE_REMOVE, 5);
    for (int i = 0; i < 17; i++) begin
      key = i[1] ? 32'sh7fffffff : (i[2] ? 32'sh80000000 : -i);
      if (i[0]) send_request(MODE_PUSH_BACK, key);
      else send_request(MODE_PUSH_FRONT, key);
    end
    send_request(MODE_AVERAGE, 0);
    send_request(MODE_REPLACE, 0);
    send_request(MODE_REMOVE, 32'sh7fffffff);
    send_request(MODE_CLEAR, 0);

    for (int n = 0; n < 950; n++) begin
      quiet = (n >= 400 && n < 550);
      key = pick_word();
      case ($urandom_range(19))
        0, 1, 2, 3, 4: send_request(MODE_PUSH_BACK, key);
        5, 6, 7, 8:    send_request(MODE_PUSH_FRONT, key);
        9, 10:         send_request(MODE_POP_FRONT, key);
        11, 12:        send_request(MODE_POP_BACK, key);
        13, 14: begin
          if ($urandom_range(1) == 0) key = word_t'($urandom_range(7)) - 3;
          send_request(MODE_REMOVE, key);
        end
        15, 16:        send_request(MODE_AVERAGE, key);
        17:            send_request(MODE_REPLACE, key);
        default: begin
          if ($urandom_range(3) == 0) send_request(MODE_CLEAR, key);
          else send_request(MODE_PUSH_BACK, key);
        end
      endcase
    end
    in_valid <= 1'b0;
    quiet = 0;

    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end
endmodule
